// ===== sv/dcl_pkg.sv =====
// ----------------------------------------------------------------------------
// dcl_pkg
// Shared types and constants of the dial combination lock.
// ----------------------------------------------------------------------------
package dcl_pkg;

  // Number of digits in the unlock code and in the entry buffer.
  localparam int unsigned CodeLength  = 4;
  // Number of code registers reachable through the configuration port.
  localparam int unsigned NumCodeRegs = 4;

  localparam int unsigned DigitW       = 4;
  localparam int unsigned CntW         = $clog2(CodeLength + 1);
  localparam int unsigned DigIdxW      = (CodeLength > 1) ? $clog2(CodeLength) : 1;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned DigitsOutW   = 3;

  localparam logic [DigitW-1:0] DialMax = DigitW'(9);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegCodeDigit0 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegCodeDigit1 = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegCodeDigit2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegCodeDigit3 = CfgIdxW'(3);

  typedef logic [DigitW-1:0] digit_t;
  typedef digit_t [CodeLength-1:0] digit_arr_t;

  // Code loaded at reset, first digit at index 0.
  localparam digit_t [NumCodeRegs-1:0] ResetCode = {
    DigitW'(0), DigitW'(1), DigitW'(0), DigitW'(1)
  };

  typedef enum logic {
    DirUp   = 1'b0,
    DirDown = 1'b1
  } dir_e;

  // Architectural state of the lock.
  typedef struct packed {
    logic            locked;
    dir_e            dir;
    logic [CntW-1:0] count;
    digit_t          dial;
  } lock_state_t;

  // Request to store the dial digit into the entry buffer.
  typedef struct packed {
    logic               en;
    logic [DigIdxW-1:0] idx;
    digit_t             digit;
  } store_req_t;

endpackage

// ===== sv/dcl_step.sv =====
// ----------------------------------------------------------------------------
// dcl_step
// Next-state logic of the lock for one polled key sample.
// ----------------------------------------------------------------------------
module dcl_step (
  input  dcl_pkg::lock_state_t cur_i,
  input  dcl_pkg::digit_arr_t  entered_i,
  input  dcl_pkg::digit_arr_t  code_i,
  input  logic                 key_up_i,
  input  logic                 key_down_i,
  input  logic                 key_clear_i,
  output dcl_pkg::lock_state_t nxt_o,
  output dcl_pkg::store_req_t  store_o
);

  logic          match;
  logic          step_ok;
  dcl_pkg::dir_e dir;

  // Full compare of the entry buffer with the code.
  always_comb begin
    match = 1'b1;
    for (int j = 0; j < dcl_pkg::CodeLength; j++) begin
      if (entered_i[j] != code_i[j]) begin
        match = 1'b0;
      end
    end
  end

  // Keys have priority in the order up, down, clear.
  always_comb begin
    nxt_o         = cur_i;
    store_o.en    = 1'b0;
    store_o.idx   = cur_i.count[dcl_pkg::DigIdxW-1:0];
    store_o.digit = cur_i.dial;
    step_ok       = 1'b0;
    dir           = key_up_i ? dcl_pkg::DirUp : dcl_pkg::DirDown;

    if (!cur_i.locked) begin
      // Unlocked: only clear has an effect, and it relocks.
      if (key_clear_i) begin
        nxt_o.locked = 1'b1;
      end
    end else if (key_up_i || key_down_i) begin
      step_ok = 1'b1;
      if (cur_i.dir != dir) begin
        if (cur_i.count >= dcl_pkg::CntW'(dcl_pkg::CodeLength)) begin
          // Buffer full: the direction change only checks the code.
          step_ok = 1'b0;
          if (match) begin
            nxt_o.locked = 1'b0;
          end
        end else begin
          nxt_o.dir   = dir;
          store_o.en  = 1'b1;
          nxt_o.count = cur_i.count + dcl_pkg::CntW'(1);
        end
      end
      if (step_ok) begin
        if (dir == dcl_pkg::DirUp) begin
          nxt_o.dial = (cur_i.dial >= dcl_pkg::DialMax) ? '0
                                                        : cur_i.dial + dcl_pkg::DigitW'(1);
        end else begin
          nxt_o.dial = (cur_i.dial == '0) ? dcl_pkg::DialMax
                                          : cur_i.dial - dcl_pkg::DigitW'(1);
        end
      end
    end else if (key_clear_i) begin
      nxt_o.count = '0;
    end
  end

endmodule

// ===== sv/dial_combination_lock.sv =====
// ----------------------------------------------------------------------------
// dial_combination_lock
// Four-digit dial combination lock with a registered result channel.
// ----------------------------------------------------------------------------
// Each accepted item is one key poll and produces exactly one result item in the
// next cycle, holding the lock flag, dial digit and stored-digit count after
// that poll. An item can be accepted in every cycle: the whole update is one
// pass of next-state logic between the lock state registers and the result
// register, and the input is ready whenever the result register is empty or
// being emptied in the same cycle. The configuration port is always ready;
// writes to indexes beyond the code registers are ignored.
module dial_combination_lock (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          key_up_i,
  input  logic                          key_down_i,
  input  logic                          key_clear_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          is_locked_o,
  output logic [dcl_pkg::DigitW-1:0]    dial_digit_o,
  output logic [dcl_pkg::DigitsOutW-1:0] digits_entered_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dcl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dcl_pkg::DigitW-1:0]    cfg_data_i
);

  dcl_pkg::lock_state_t state_q, state_d;
  dcl_pkg::store_req_t  store;
  dcl_pkg::digit_arr_t  entered_q;
  dcl_pkg::digit_arr_t  code_q;
  logic                 in_acc;
  logic                 out_valid_q;
  logic                 locked_out_q;
  dcl_pkg::digit_t      dial_out_q;
  logic [dcl_pkg::DigitsOutW-1:0] count_out_q;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  dcl_step u_step (
    .cur_i       (state_q),
    .entered_i   (entered_q),
    .code_i      (code_q),
    .key_up_i    (key_up_i),
    .key_down_i  (key_down_i),
    .key_clear_i (key_clear_i),
    .nxt_o       (state_d),
    .store_o     (store)
  );

  // Lock state advances once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.locked <= 1'b1;
      state_q.dir    <= dcl_pkg::DirUp;
      state_q.count  <= '0;
      state_q.dial   <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Entry buffer holds no reset value; it is read only once full.
  always_ff @(posedge clk_i) begin
    if (in_acc && store.en) begin
      entered_q[store.idx] <= store.digit;
    end
  end

  // Code registers, written through the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < dcl_pkg::CodeLength; j++) begin
        code_q[j] <= (j < dcl_pkg::NumCodeRegs) ? dcl_pkg::ResetCode[j] : '0;
      end
    end else if (cfg_valid_i
                 && cfg_index_i <= dcl_pkg::RegCodeDigit3
                 && cfg_index_i < dcl_pkg::CfgIdxW'(dcl_pkg::CodeLength)) begin
      code_q[cfg_index_i[dcl_pkg::DigIdxW-1:0]] <= cfg_data_i;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: the state after the accepted poll.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      locked_out_q <= state_d.locked;
      dial_out_q   <= state_d.dial;
      count_out_q  <= dcl_pkg::DigitsOutW'(state_d.count);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_locked_o      = locked_out_q;
  assign dial_digit_o     = dial_out_q;
  assign digits_entered_o = count_out_q;

  // The stored-digit count never passes the code length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.count <= dcl_pkg::CntW'(dcl_pkg::CodeLength))
    else $error("entry count above code length");

  // Unlocking happens only with a full entry buffer.
  a_unlock_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.locked && !state_d.locked && in_acc)
      |-> (state_q.count == dcl_pkg::CntW'(dcl_pkg::CodeLength)))
    else $error("unlock without a full entry buffer");

  // While unlocked the dial and the count do not move.
  a_unlocked_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!state_q.locked && in_acc)
      |=> ($stable(state_q.dial) && $stable(state_q.count)))
    else $error("dial moved while unlocked");

  // A result is shown in the cycle after each accepted item.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted item produced no result");

endmodule

// ===== tb/tb_dial_combination_lock.sv =====
// ----------------------------------------------------------------------------
// tb_dial_combination_lock
// Self-checking testbench for the dial combination lock.
// ----------------------------------------------------------------------------
// A scoreboard class tracks the lock state and code digits, and predicts the
// result of every key poll the block accepts. A short directed opening covers
// dial wrap, key priority, clear, unlock, relock and a failed compare. Random
// polls then mostly dial in whole codes, right or slightly wrong, mixed with
// noise. Several code settings are used, including all zeros, all nines, a
// digit that can never match and writes to indexes beyond the code registers.
// Both sides idle at random, and the result side once holds off long enough
// to stall the input.
// ----------------------------------------------------------------------------
module tb_dial_combination_lock;
  timeunit 1ns;
  timeprecision 1ps;

  // Key patterns, one bit per key.
  localparam logic [2:0] KeyNone  = 3'b000;
  localparam logic [2:0] KeyUp    = 3'b001;
  localparam logic [2:0] KeyDown  = 3'b010;
  localparam logic [2:0] KeyClear = 3'b100;

  // Indexes that hold no code register; writes to them must be ignored.
  localparam logic [dcl_pkg::CfgIdxW-1:0] RegSpareLow = dcl_pkg::CfgIdxW'(4);
  localparam logic [dcl_pkg::CfgIdxW-1:0] RegSpareTop = dcl_pkg::CfgIdxW'(7);

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldOffAt  = 300;
  localparam int unsigned HoldOffLen = 300;

  // Directed opening under the reset code.
  localparam logic [2:0] Opening [24] = '{
    KeyDown, KeyUp | KeyDown | KeyClear, KeyClear, KeyNone,
    KeyUp, KeyDown, KeyUp, KeyDown, KeyUp, KeyUp, KeyUp | KeyClear, KeyDown,
    KeyUp, KeyUp | KeyDown, KeyClear, KeyDown, KeyUp | KeyClear, KeyClear,
    KeyDown, KeyUp, KeyDown, KeyUp, KeyDown | KeyClear, KeyClear
  };

  // Lock flag, dial digit and stored-digit count after one poll.
  typedef struct packed {
    logic                           locked;
    dcl_pkg::digit_t                dial;
    logic [dcl_pkg::DigitsOutW-1:0] entered;
  } lock_view_t;

  // Tracks the lock, predicts each result and checks the results in order.
  class dial_lock_scoreboard;
    dcl_pkg::digit_t          code [dcl_pkg::CodeLength];
    dcl_pkg::digit_t          stored [dcl_pkg::CodeLength];
    dcl_pkg::digit_t          dial;
    dcl_pkg::dir_e            dir;
    logic [dcl_pkg::CntW-1:0] count;
    bit                       locked;
    lock_view_t               pending_views [$];
    int unsigned              errors, n_checked, n_unlocks, n_relocks, n_refused;

    function new();
      for (int i = 0; i < dcl_pkg::CodeLength; i++) begin
        code[i]   = (i < dcl_pkg::NumCodeRegs) ? dcl_pkg::ResetCode[i] : '0;
        stored[i] = '0;
      end
      dial   = '0;
      dir    = dcl_pkg::DirUp;
      count  = '0;
      locked = 1'b1;
    endfunction

    function void note_reg(logic [dcl_pkg::CfgIdxW-1:0] idx, dcl_pkg::digit_t value);
      if (int'(idx) < dcl_pkg::NumCodeRegs && int'(idx) < dcl_pkg::CodeLength) begin
        code[idx[dcl_pkg::DigIdxW-1:0]] = value;
      end
    endfunction

    // A turn of the dial stores the digit, or compares once the buffer is full.
    // Returns whether the dial may still step on this poll.
    function bit turn(dcl_pkg::dir_e d);
      bit same;
      if (dir == d) return 1'b1;
      if (count >= dcl_pkg::CodeLength) begin
        same = 1'b1;
        for (int i = 0; i < dcl_pkg::CodeLength; i++) if (stored[i] != code[i]) same = 1'b0;
        if (same) begin
          locked = 1'b0;
          n_unlocks++;
        end else begin
          n_refused++;
        end
        return 1'b0;
      end
      dir                                = d;
      stored[count[dcl_pkg::DigIdxW-1:0]] = dial;
      count++;
      return 1'b1;
    endfunction

    function void note_keys(logic [2:0] keys);
      lock_view_t view;
      if (!locked) begin
        if (keys & KeyClear) begin
          locked = 1'b1;
          n_relocks++;
        end
      end else if (keys & KeyUp) begin
        if (turn(dcl_pkg::DirUp)) begin
          dial = (dial >= dcl_pkg::DialMax) ? '0 : dial + dcl_pkg::DigitW'(1);
        end
      end else if (keys & KeyDown) begin
        if (turn(dcl_pkg::DirDown)) begin
          dial = (dial == '0) ? dcl_pkg::DialMax : dial - dcl_pkg::DigitW'(1);
        end
      end else if (keys & KeyClear) begin
        count = '0;
      end
      view.locked  = locked;
      view.dial    = dial;
      view.entered = dcl_pkg::DigitsOutW'(count);
      pending_views.push_back(view);
    endfunction

    function void check_result(lock_view_t got);
      lock_view_t want;
      if (pending_views.size() == 0) begin
        $error("result item with no prediction waiting: %p", got);
        errors++;
        return;
      end
      want = pending_views.pop_front();
      n_checked++;
      if (got.locked !== want.locked) begin
        $error("is_locked: expected %0d, got %0d", want.locked, got.locked);
        errors++;
      end
      if (got.dial !== want.dial) begin
        $error("dial_digit: expected %0d, got %0d", want.dial, got.dial);
        errors++;
      end
      if (got.entered !== want.entered) begin
        $error("digits_entered: expected %0d, got %0d", want.entered, got.entered);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_views.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic                           key_up_i = 1'b0;
  logic                           key_down_i = 1'b0;
  logic                           key_clear_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic                           is_locked_o;
  logic [dcl_pkg::DigitW-1:0]     dial_digit_o;
  logic [dcl_pkg::DigitsOutW-1:0] digits_entered_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [dcl_pkg::CfgIdxW-1:0]    cfg_index_i = '0;
  logic [dcl_pkg::DigitW-1:0]     cfg_data_i = '0;

  dial_lock_scoreboard sb = new();

  // Random dialling: the code being aimed at, and whether a new attempt is due.
  dcl_pkg::digit_t target [dcl_pkg::CodeLength];
  bit              restart = 1'b1;
  int unsigned     n_polls, n_settings;
  bit              steady_in;

  always #2 clk_i = ~clk_i;

  dial_combination_lock i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .key_up_i,
    .key_down_i,
    .key_clear_i,
    .out_valid_o,
    .out_ready_i,
    .is_locked_o,
    .dial_digit_o,
    .digits_entered_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  function automatic int unsigned draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  // One dial step in the given direction, with keys of lower priority added at random.
  function automatic logic [2:0] step_keys(dcl_pkg::dir_e d);
    logic [2:0] keys;
    keys = $urandom_range(0, 1) ? KeyClear : KeyNone;
    if (d == dcl_pkg::DirUp) begin
      keys |= KeyUp | ($urandom_range(0, 1) ? KeyDown : KeyNone);
    end else begin
      keys |= KeyDown;
    end
    return keys;
  endfunction

  // Next poll of a dialling attempt, worked out from the tracked lock state.
  function automatic logic [2:0] plan_keys();
    dcl_pkg::dir_e turned;
    int            pick;
    turned = (sb.dir == dcl_pkg::DirUp) ? dcl_pkg::DirDown : dcl_pkg::DirUp;
    if ($urandom_range(0, 99) < 12) return 3'($urandom);
    if (!sb.locked) begin
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1) ? KeyUp | KeyDown : KeyDown;
      restart = 1'b1;
      return KeyClear | 3'($urandom_range(0, 3));
    end
    if (restart) begin
      // Aim mostly at the code, sometimes one digit off, sometimes anywhere.
      pick = $urandom_range(0, 9);
      for (int i = 0; i < dcl_pkg::CodeLength; i++) begin
        target[i] = (pick < 8 && sb.code[i] <= dcl_pkg::DialMax)
                    ? sb.code[i] : dcl_pkg::digit_t'($urandom_range(0, 9));
      end
      if (pick >= 6 && pick < 8) target[$urandom_range(0, dcl_pkg::CodeLength - 1)] =
          dcl_pkg::digit_t'($urandom_range(0, 9));
      restart = 1'b0;
      return KeyClear;
    end
    if (sb.count >= dcl_pkg::CodeLength) begin
      restart = 1'b1;
      return step_keys(turned);
    end
    if (sb.dial != target[sb.count[dcl_pkg::DigIdxW-1:0]]) return step_keys(sb.dir);
    return step_keys(turned);
  endfunction

  // Offer one poll after a random gap and wait until the block takes it.
  task automatic send_keys(logic [2:0] keys);
    int unsigned gap;
    if (n_polls % 50 == 0) steady_in = ($urandom_range(0, 3) == 0);
    gap = draw_gap(steady_in);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    key_up_i    <= |(keys & KeyUp);
    key_down_i  <= |(keys & KeyDown);
    key_clear_i <= |(keys & KeyClear);
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_keys(keys);
    n_polls++;
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) send_keys(plan_keys());
  endtask

  // Stop offering polls and wait until every predicted result has arrived.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [dcl_pkg::CfgIdxW-1:0] idx, dcl_pkg::digit_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_reg(idx, value);
  endtask

  task automatic program_code(dcl_pkg::digit_t d0, dcl_pkg::digit_t d1,
                              dcl_pkg::digit_t d2, dcl_pkg::digit_t d3);
    write_reg(dcl_pkg::RegCodeDigit0, d0);
    write_reg(dcl_pkg::RegCodeDigit1, d1);
    write_reg(dcl_pkg::RegCodeDigit2, d2);
    write_reg(dcl_pkg::RegCodeDigit3, d3);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Result side: random stalls, and one long hold-off that backs up the input.
  initial begin : result_sink
    int unsigned gap, n_taken;
    bit          steady_out;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (n_taken % 40 == 0) steady_out = ($urandom_range(0, 3) == 0);
      gap = (n_taken == HoldOffAt) ? HoldOffLen : draw_gap(steady_out);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result('{is_locked_o, dial_digit_o, digits_entered_o});
      n_taken++;
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  initial begin : watchdog
    int unsigned quiet;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("timeout after %0d quiet cycles, %0d results outstanding",
                 quiet, sb.pending());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed opening, then random phases per code setting.
  initial begin : stimulus
    dcl_pkg::digit_t odd [dcl_pkg::CodeLength];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Opening[i]) send_keys(Opening[i]);
    run_random(250);
    settle();

    // Lowest code; spare indexes written with values that would otherwise matter.
    write_reg(RegSpareLow, dcl_pkg::digit_t'(15));
    write_reg(RegSpareTop, dcl_pkg::digit_t'(0));
    program_code(dcl_pkg::digit_t'(0), dcl_pkg::digit_t'(0),
                 dcl_pkg::digit_t'(0), dcl_pkg::digit_t'(0));
    run_random(250);
    settle();

    program_code(dcl_pkg::DialMax, dcl_pkg::DialMax, dcl_pkg::DialMax, dcl_pkg::DialMax);
    run_random(250);
    settle();

    // One digit out of dial range, so the code can never open.
    foreach (odd[i]) odd[i] = dcl_pkg::digit_t'($urandom_range(0, 9));
    odd[$urandom_range(0, dcl_pkg::CodeLength - 1)] = dcl_pkg::digit_t'(15);
    program_code(odd[0], odd[1], odd[2], odd[3]);
    run_random(200);
    settle();

    program_code(dcl_pkg::digit_t'($urandom_range(0, 9)),
                 dcl_pkg::digit_t'($urandom_range(0, 9)),
                 dcl_pkg::digit_t'($urandom_range(0, 9)),
                 dcl_pkg::digit_t'($urandom_range(0, 9)));
    run_random(300);
    settle();
    repeat (4) @(posedge clk_i);

    $display("%0d polls over %0d code settings, %0d results checked, %0d errors",
             n_polls, n_settings + 1, sb.n_checked, sb.errors);
    $display("%0d unlocks, %0d refused compares, %0d relocks",
             sb.n_unlocks, sb.n_refused, sb.n_relocks);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
